### rtl/pdm_pkg.sv
// Shared constants, types and helper functions of the particle drift map unit.
`default_nettype none

package pdm_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 48;
    localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] S64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64MIN = 64'h8000_0000_0000_0000;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIFT_LENGTH = 3'd0,
        CFG_REF_MOMENTUM = 3'd1,
        CFG_MASS         = 3'd2,
        CFG_REF_CDT      = 3'd3
    } cfg_idx_t;

    localparam logic [63:0] RST_DRIFT_LENGTH = 64'd591097451092378;
    localparam logic [62:0] RST_REF_MOMENTUM = 63'd281474976710656;
    localparam logic [62:0] RST_MASS         = 63'd0;
    localparam logic [63:0] RST_REF_CDT      = 64'd97108866965176;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Unit latencies in cycles, and the divider quotient width
    localparam int MUL_LAT  = 2;
    localparam int SQRT_LAT = 64;
    localparam int DIV_LAT  = 65;
    localparam int QW       = 66;

    // Classified particle handed from front to back
    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] time_offset;
        logic [63:0] adp;
        logic [63:0] axp;
        logic [63:0] ayp;
        logic [63:0] al;
        logic        sx;
        logic        sy;
    } item_t;

    typedef struct packed {
        logic [QPTR_W:0] count;
    } q_status_t;

    // Magnitude of a two's complement word
    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Saturate a wide signed sum to 64 bits
    function automatic logic [63:0] sat68(input logic [67:0] v);
        if (v[67:63] == {5{v[67]}})
            return v[63:0];
        else
            return v[67] ? S64MIN : S64MAX;
    endfunction

endpackage

`default_nettype wire

### rtl/pdm_chan_if.sv
// Particle input and result output channel interfaces.
`default_nettype none

interface pdm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] pos_x;
    logic [63:0] slope_x;
    logic [63:0] pos_y;
    logic [63:0] slope_y;
    logic [63:0] time_offset;
    logic [63:0] momentum_dev;

    modport source (output valid, pos_x, slope_x, pos_y, slope_y, time_offset,
                    momentum_dev, input ready);
    modport sink (input valid, pos_x, slope_x, pos_y, slope_y, time_offset,
                  momentum_dev, output ready);
endinterface

interface pdm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] new_x;
    logic [63:0] new_y;
    logic [63:0] new_time_offset;
    logic        math_error;

    modport source (output valid, new_x, new_y, new_time_offset, math_error,
                    input ready);
    modport sink (input valid, new_x, new_y, new_time_offset, math_error,
                  output ready);
endinterface

`default_nettype wire

### rtl/pdm_front.sv
// Front end: accepts particles and classifies them into magnitudes and signs.
`default_nettype none

module pdm_front (
    input  logic          clk,
    input  logic          rst_n,
    pdm_in_if.sink        particle,
    input  logic [63:0]   drift_length,
    output pdm_pkg::item_t item,
    output logic          item_valid,
    input  logic          item_ready
);
    import pdm_pkg::*;

    item_t       item_reg;
    item_t       item_next;
    logic        vld_reg;
    logic [63:0] dp;

    assign particle.ready = !vld_reg || item_ready;
    assign item           = item_reg;
    assign item_valid     = vld_reg;

    // Classify the incoming particle
    always_comb
    begin
        dp = particle.momentum_dev + ONE;
        if (!particle.momentum_dev[63] && dp[63])
            dp = S64MAX;
        item_next.pos_x       = particle.pos_x;
        item_next.pos_y       = particle.pos_y;
        item_next.time_offset = particle.time_offset;
        item_next.adp         = mag(dp);
        item_next.axp         = mag(particle.slope_x);
        item_next.ayp         = mag(particle.slope_y);
        item_next.al          = mag(drift_length);
        item_next.sx          = particle.slope_x[63] ^ drift_length[63];
        item_next.sy          = particle.slope_y[63] ^ drift_length[63];
    end

    // Hold the classified transaction until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (particle.ready)
            vld_reg <= particle.valid;
    end

    always_ff @(posedge clk)
    begin
        if (particle.ready && particle.valid)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

### rtl/pdm_fifo.sv
// Short queue of classified particles between front and back.
`default_nettype none

module pdm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  pdm_pkg::item_t    wr_item,
    input  logic              wr_valid,
    output logic              wr_ready,
    output pdm_pkg::item_t    rd_item,
    output logic              rd_valid,
    input  logic              rd_ready,
    output pdm_pkg::q_status_t status
);
    import pdm_pkg::*;

    item_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign wr_ready     = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign rd_valid     = (count_reg != '0);
    assign push         = wr_valid && wr_ready;
    assign pop          = rd_valid && rd_ready;
    assign rd_item      = mem[rd_ptr_reg];
    assign status.count = count_reg;

    // Store pushed transactions
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/pdm_mul64.sv
// Two-stage 64 x 64 unsigned multiplier built from 32 x 32 partial products.
`default_nettype none

module pdm_mul64 (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic [127:0]  p
);
    logic [63:0]  ll_reg;
    logic [63:0]  lh_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic [127:0] p_reg;

    assign p = p_reg;

    // Form partial products, then combine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[31:0]  * b[31:0];
            lh_reg <= a[31:0]  * b[63:32];
            hl_reg <= a[63:32] * b[31:0];
            hh_reg <= a[63:32] * b[63:32];
            p_reg  <= {hh_reg, ll_reg} + {32'd0, lh_reg, 32'd0}
                      + {32'd0, hl_reg, 32'd0};
        end
    end

endmodule

`default_nettype wire

### rtl/pdm_sqrt.sv
// Pipelined integer square root of a 128-bit value, one root bit per stage.
`default_nettype none

module pdm_sqrt (
    input  logic          clk,
    input  logic          en,
    input  logic [127:0]  v,
    output logic [63:0]   root
);
    import pdm_pkg::*;

    logic [65:0]  rem_reg  [SQRT_LAT];
    logic [63:0]  root_reg [SQRT_LAT];
    logic [127:0] val_reg  [SQRT_LAT];

    assign root = root_reg[SQRT_LAT-1];

    for (genvar k = 0; k < SQRT_LAT; k++)
    begin : g_stage
        logic [65:0]  rem_in;
        logic [63:0]  root_in;
        logic [127:0] val_in;
        logic [67:0]  cur;
        logic [67:0]  trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = v;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        // Bring in two bits and try the next root bit
        assign cur   = {rem_in, val_in[127:126]};
        assign trial = cur - {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!trial[67])
                begin
                    rem_reg[k]  <= trial[65:0];
                    root_reg[k] <= {root_in[62:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= cur[65:0];
                    root_reg[k] <= {root_in[62:0], 1'b0};
                end
                val_reg[k] <= {val_in[125:0], 2'b00};
            end
        end
    end

endmodule

`default_nettype wire

### rtl/pdm_div.sv
// Pipelined 128 / 64 restoring divider, quotient capped at 2^65.
`default_nettype none

module pdm_div (
    input  logic           clk,
    input  logic           en,
    input  logic [127:0]   num,
    input  logic [63:0]    den,
    output logic [pdm_pkg::QW-1:0] q
);
    import pdm_pkg::*;

    logic [63:0] rem_reg [DIV_LAT];
    logic [64:0] quo_reg [DIV_LAT];
    logic [64:0] low_reg [DIV_LAT];
    logic [63:0] den_reg [DIV_LAT];
    logic        ovf_reg [DIV_LAT];

    assign q = ovf_reg[DIV_LAT-1] ? (QW'(1) << 65) : {1'b0, quo_reg[DIV_LAT-1]};

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_stage
        logic [63:0] rem_in;
        logic [64:0] quo_in;
        logic [64:0] low_in;
        logic [63:0] den_in;
        logic        ovf_in;
        logic [64:0] cur;
        logic        ge;

        if (k == 0)
        begin : g_first
            // Quotient reaches 2^65 exactly when the top bits reach the divisor
            assign rem_in = {1'b0, num[127:65]};
            assign quo_in = '0;
            assign low_in = num[64:0];
            assign den_in = den;
            assign ovf_in = ({1'b0, num[127:65]} >= den);
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        // Shift in one dividend bit and subtract where it fits
        assign cur = {rem_in, low_in[64]};
        assign ge  = (cur >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? 64'(cur - {1'b0, den_in}) : cur[63:0];
                quo_reg[k] <= {quo_in[63:0], ge};
                low_reg[k] <= {low_in[63:0], 1'b0};
                den_reg[k] <= den_in;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/pdm_back.sv
// Back end: pipelined drift arithmetic from queued particles to results.
`default_nettype none

module pdm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pdm_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_ready,
    input  logic [62:0]    ref_momentum,
    input  logic [62:0]    particle_mass,
    input  logic [63:0]    ref_cdt,
    pdm_out_if.source      result
);
    import pdm_pkg::*;

    // Pipeline timing, counted from the queue head
    localparam int T_PROD = MUL_LAT;
    localparam int T_B1   = T_PROD + 1;
    localparam int T_B2   = T_B1 + 1;
    localparam int T_N    = T_B2 + SQRT_LAT;
    localparam int T_EP   = T_B2 + MUL_LAT;
    localparam int T_ES   = T_EP + 1;
    localparam int T_E    = T_ES + SQRT_LAT;
    localparam int T_Q    = T_N + DIV_LAT;
    localparam int T_TP   = T_Q + MUL_LAT;
    localparam int T_TQ   = T_TP + DIV_LAT;
    localparam int LAT    = T_TQ + 1;
    localparam int D_NUM  = T_N - T_PROD;
    localparam int D_E    = T_Q - T_E;
    localparam int D_QQ   = T_TQ - T_Q;
    localparam int D_MID  = T_TQ - T_B2;
    localparam int PM_TAP = T_TP - T_B2 - 1;

    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] time_offset;
        logic        sx;
        logic        sy;
    } side_t;

    typedef struct packed {
        logic        err;
        logic [62:0] pm;
    } mid_t;

    logic         en;
    logic         vld_reg [LAT];
    side_t        side_dly [T_TQ];
    mid_t         mid_dly [D_MID];
    logic [127:0] nx_dly [D_NUM];
    logic [127:0] ny_dly [D_NUM];
    logic [127:0] nd_dly [D_NUM];
    logic [63:0]  e_dly [D_E];
    logic [QW-1:0] qx_dly [D_QQ];
    logic [QW-1:0] qy_dly [D_QQ];

    logic [127:0] dp2_p, xx_p, yy_p, ph_p, nx_p, ny_p, nd_p;
    logic [128:0] s2_reg;
    logic [127:0] dp2_reg;
    logic [62:0]  pm_b1_reg;
    logic [127:0] rad_reg;
    logic         err_reg;
    logic [62:0]  pm_b2_reg;
    logic [127:0] pp_p, mm_p;
    logic [127:0] esum_reg;
    logic [63:0]  energy;
    logic [63:0]  n_root;
    logic [QW-1:0] qx_q, qy_q, dd_q, term_q;
    logic [63:0]  pathlen;
    logic [127:0] te_p;
    side_t        side_o;
    mid_t         mid_o;
    logic [QW-1:0] qx_o, qy_o;

    logic [63:0]  new_x_reg, new_y_reg, new_t_reg;
    logic         err_out_reg;

    // Advance the whole pipeline unless the result is stalled
    assign en         = !vld_reg[LAT-1] || result.ready;
    assign item_ready = en;

    // Products of the queued operands
    pdm_mul64 u_dp2 (.clk(clk), .en(en), .a(item.adp), .b(item.adp), .p(dp2_p));
    pdm_mul64 u_xx  (.clk(clk), .en(en), .a(item.axp), .b(item.axp), .p(xx_p));
    pdm_mul64 u_yy  (.clk(clk), .en(en), .a(item.ayp), .b(item.ayp), .p(yy_p));
    pdm_mul64 u_ph  (.clk(clk), .en(en), .a(item.adp), .b({1'b0, ref_momentum}),
                     .p(ph_p));
    pdm_mul64 u_nx  (.clk(clk), .en(en), .a(item.axp), .b(item.al), .p(nx_p));
    pdm_mul64 u_ny  (.clk(clk), .en(en), .a(item.ayp), .b(item.al), .p(ny_p));
    pdm_mul64 u_nd  (.clk(clk), .en(en), .a(item.al), .b(item.adp), .p(nd_p));

    // Sum squared slopes and saturate the momentum, then form the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg    <= {1'b0, xx_p} + {1'b0, yy_p};
            dp2_reg   <= dp2_p;
            pm_b1_reg <= (|ph_p[127:FRAC_BITS+63]) ? S64MAX[62:0]
                                                   : ph_p[FRAC_BITS+62:FRAC_BITS];
            rad_reg   <= 128'({1'b0, dp2_reg} - s2_reg);
            err_reg   <= ({1'b0, dp2_reg} <= s2_reg) || (pm_b1_reg == '0);
            pm_b2_reg <= pm_b1_reg;
        end
    end

    // Energy from momentum and mass
    pdm_mul64 u_pp (.clk(clk), .en(en), .a({1'b0, pm_b2_reg}), .b({1'b0, pm_b2_reg}),
                    .p(pp_p));
    pdm_mul64 u_mm (.clk(clk), .en(en), .a({1'b0, particle_mass}),
                    .b({1'b0, particle_mass}), .p(mm_p));

    always_ff @(posedge clk)
    begin
        if (en)
            esum_reg <= pp_p + mm_p;
    end

    pdm_sqrt u_esq (.clk(clk), .en(en), .v(esum_reg), .root(energy));
    pdm_sqrt u_nsq (.clk(clk), .en(en), .v(rad_reg), .root(n_root));

    // Delay lines that line operands up with the unit outputs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly[0] <= '{pos_x: item.pos_x, pos_y: item.pos_y,
                             time_offset: item.time_offset, sx: item.sx, sy: item.sy};
            for (int i = 1; i < T_TQ; i++)
                side_dly[i] <= side_dly[i-1];
            mid_dly[0] <= '{err: err_reg, pm: pm_b2_reg};
            for (int i = 1; i < D_MID; i++)
                mid_dly[i] <= mid_dly[i-1];
            nx_dly[0] <= nx_p;
            ny_dly[0] <= ny_p;
            nd_dly[0] <= nd_p;
            for (int i = 1; i < D_NUM; i++)
            begin
                nx_dly[i] <= nx_dly[i-1];
                ny_dly[i] <= ny_dly[i-1];
                nd_dly[i] <= nd_dly[i-1];
            end
            e_dly[0] <= energy;
            for (int i = 1; i < D_E; i++)
                e_dly[i] <= e_dly[i-1];
            qx_dly[0] <= qx_q;
            qy_dly[0] <= qy_q;
            for (int i = 1; i < D_QQ; i++)
            begin
                qx_dly[i] <= qx_dly[i-1];
                qy_dly[i] <= qy_dly[i-1];
            end
        end
    end

    // Position steps and path length
    pdm_div u_dx (.clk(clk), .en(en), .num(nx_dly[D_NUM-1]), .den(n_root), .q(qx_q));
    pdm_div u_dy (.clk(clk), .en(en), .num(ny_dly[D_NUM-1]), .den(n_root), .q(qy_q));
    pdm_div u_dd (.clk(clk), .en(en), .num(nd_dly[D_NUM-1]), .den(n_root), .q(dd_q));

    // Time term: path times energy over momentum
    assign pathlen = (|dd_q[QW-1:64]) ? '1 : dd_q[63:0];

    pdm_mul64 u_te (.clk(clk), .en(en), .a(pathlen), .b(e_dly[D_E-1]), .p(te_p));
    pdm_div   u_tq (.clk(clk), .en(en), .num(te_p), .den({1'b0, mid_dly[PM_TAP].pm}),
                    .q(term_q));

    assign side_o = side_dly[T_TQ-1];
    assign mid_o  = mid_dly[D_MID-1];
    assign qx_o   = qx_dly[D_QQ-1];
    assign qy_o   = qy_dly[D_QQ-1];

    // Apply steps with saturation, or pass inputs through on error
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_out_reg <= mid_o.err;
            if (mid_o.err)
            begin
                new_x_reg <= side_o.pos_x;
                new_y_reg <= side_o.pos_y;
                new_t_reg <= side_o.time_offset;
            end
            else
            begin
                new_x_reg <= sat68({{4{side_o.pos_x[63]}}, side_o.pos_x}
                                   + (side_o.sx ? (68'd0 - {2'b00, qx_o}) : {2'b00, qx_o}));
                new_y_reg <= sat68({{4{side_o.pos_y[63]}}, side_o.pos_y}
                                   + (side_o.sy ? (68'd0 - {2'b00, qy_o}) : {2'b00, qy_o}));
                new_t_reg <= sat68({{4{side_o.time_offset[63]}}, side_o.time_offset}
                                   + {2'b00, term_q}
                                   - {{4{ref_cdt[63]}}, ref_cdt});
            end
        end
    end

    // Track which stages hold a live transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign result.valid           = vld_reg[LAT-1];
    assign result.new_x           = new_x_reg;
    assign result.new_y           = new_y_reg;
    assign result.new_time_offset = new_t_reg;
    assign result.math_error      = err_out_reg;

endmodule

`default_nettype wire

### rtl/particle_drift_map_unit.sv
// Particle drift map unit: top level with configuration registers.
// Exact field-free drift of one particle per transaction in signed Q15.48:
// x and y advance by slope*L/n, cdt by path*E/p minus the reference cdt,
// with n = sqrt((1+dpop)^2 - xp^2 - yp^2); all results saturate, and a
// non-positive radicand or zero momentum sets math_error and passes the
// positions and cdt through. One particle is accepted per clock unless the
// queue is full or the result is stalled; a result passes the front register,
// the queue and the back pipeline, which chains one 64-step square root and two
// 65-step dividers. A four-deep queue separates the classifying front from the
// arithmetic back. Write configuration only when idle.
`default_nettype none

module particle_drift_map_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    pdm_in_if.sink                           particle,
    pdm_out_if.source                        result,
    input  logic                             cfg_write,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data
);
    import pdm_pkg::*;

    logic [63:0] drift_length_reg;
    logic [62:0] ref_momentum_reg;
    logic [62:0] mass_reg;
    logic [63:0] ref_cdt_reg;

    item_t       fe_item;
    logic        fe_valid;
    logic        fe_ready;
    item_t       q_item;
    logic        q_valid;
    logic        q_ready;
    q_status_t   q_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_length_reg <= RST_DRIFT_LENGTH;
            ref_momentum_reg <= RST_REF_MOMENTUM;
            mass_reg         <= RST_MASS;
            ref_cdt_reg      <= RST_REF_CDT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DRIFT_LENGTH: drift_length_reg <= cfg_data;
                CFG_REF_MOMENTUM: ref_momentum_reg <= cfg_data[62:0];
                CFG_MASS:         mass_reg         <= cfg_data[62:0];
                CFG_REF_CDT:      ref_cdt_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    pdm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .particle     (particle),
        .drift_length (drift_length_reg),
        .item         (fe_item),
        .item_valid   (fe_valid),
        .item_ready   (fe_ready)
    );

    pdm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (fe_item),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .status   (q_status)
    );

    pdm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (q_item),
        .item_valid    (q_valid),
        .item_ready    (q_ready),
        .ref_momentum  (ref_momentum_reg),
        .particle_mass (mass_reg),
        .ref_cdt       (ref_cdt_reg),
        .result        (result)
    );

`ifndef SYNTH
    // Front keeps its transaction while the queue is full
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fe_valid && !fe_ready |=> fe_valid)
        else $error("front dropped a stalled transaction");

    // Queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");

    // A push leaves the queue non-empty
    a_q_push: assert property (@(posedge clk) disable iff (!rst_n)
        fe_valid && fe_ready |=> q_status.count != '0)
        else $error("queue lost a pushed transaction");
`endif

endmodule

`default_nettype wire

### tb/particle_drift_map_unit_test.sv
// Self-checking testbench for the particle drift map unit: random bursts, stalls and register sweeps.
`timescale 1ns / 100ps

module particle_drift_map_unit_test;
    import pdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam int END_WAIT = 260;

    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] slope_x;
        logic [63:0] pos_y;
        logic [63:0] slope_y;
        logic [63:0] time_offset;
        logic [63:0] momentum_dev;
    } particle_t;

    typedef struct packed {
        logic [63:0] new_x;
        logic [63:0] new_y;
        logic [63:0] new_time_offset;
        logic        math_error;
    } drift_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    pdm_in_if  particle_ch ();
    pdm_out_if result_ch ();

    particle_drift_map_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .particle  (particle_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register shadow
    logic [63:0] len_reg  = RST_DRIFT_LENGTH;
    logic [62:0] mom_reg  = RST_REF_MOMENTUM;
    logic [62:0] mass_reg = RST_MASS;
    logic [63:0] tref_reg = RST_REF_CDT;

    particle_t pending_particles[$];
    drift_t    expected_drifts[$];
    int        mismatch_count = 0;

    always #4 clk = ~clk;

    initial begin
        particle_ch.valid = 1'b0;
        particle_ch.pos_x = '0;
        particle_ch.slope_x = '0;
        particle_ch.pos_y = '0;
        particle_ch.slope_y = '0;
        particle_ch.time_offset = '0;
        particle_ch.momentum_dev = '0;
        result_ch.ready = 1'b0;
    end

    // Floor square root of a 128-bit value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    // Truncating quotient, capped at 2^65
    function automatic logic [127:0] capped_div(input logic [127:0] num, input logic [63:0] d);
        logic [127:0] q;
        if (d == 0)
            return 128'd1 << 65;
        q = num / {64'd0, d};
        if (q[127:65] != 0)
            return 128'd1 << 65;
        return q;
    endfunction

    function automatic logic [63:0] sat128(input logic [127:0] v);
        if (v[127:63] == {65{v[127]}})
            return v[63:0];
        return v[127] ? S64MIN : S64MAX;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic drift_t predict_drift(input particle_t p);
        drift_t d;
        logic [63:0] dp, adp, axp, ayp, al, pm, n, pathlen, energy;
        logic [127:0] dp2, s2, ph, qx, qy, dd, term;
        dp = p.momentum_dev + ONE;
        if (!p.momentum_dev[63] && dp[63])
            dp = S64MAX;
        adp = abs64(dp);
        axp = abs64(p.slope_x);
        ayp = abs64(p.slope_y);
        al = abs64(len_reg);
        dp2 = {64'd0, adp} * {64'd0, adp};
        s2 = {64'd0, axp} * {64'd0, axp} + {64'd0, ayp} * {64'd0, ayp};
        ph = ({64'd0, adp} * {65'd0, mom_reg}) >> FRAC_BITS;
        pm = (ph[127:63] != 0) ? S64MAX : ph[63:0];
        if (dp2 <= s2 || pm == 0)
        begin
            d.new_x = p.pos_x;
            d.new_y = p.pos_y;
            d.new_time_offset = p.time_offset;
            d.math_error = 1'b1;
            return d;
        end
        n = floor_sqrt(dp2 - s2);
        qx = capped_div({64'd0, axp} * {64'd0, al}, n);
        if (p.slope_x[63] ^ len_reg[63])
            qx = 128'd0 - qx;
        qy = capped_div({64'd0, ayp} * {64'd0, al}, n);
        if (p.slope_y[63] ^ len_reg[63])
            qy = 128'd0 - qy;
        dd = capped_div({64'd0, al} * {64'd0, adp}, n);
        pathlen = (dd[127:64] != 0) ? '1 : dd[63:0];
        energy = floor_sqrt({64'd0, pm} * {64'd0, pm} + {65'd0, mass_reg} * {65'd0, mass_reg});
        term = capped_div({64'd0, pathlen} * {64'd0, energy}, pm);
        d.new_x = sat128({{64{p.pos_x[63]}}, p.pos_x} + qx);
        d.new_y = sat128({{64{p.pos_y[63]}}, p.pos_y} + qy);
        d.new_time_offset = sat128({{64{p.time_offset[63]}}, p.time_offset} + term
                                   - {{64{tref_reg[63]}}, tref_reg});
        d.math_error = 1'b0;
        return d;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Signed value with a random number of significant bits
    function automatic logic [63:0] rand_signed(input int bits);
        logic [63:0] v;
        v = rand64() >> (64 - bits);
        return $urandom_range(0, 1) ? 64'd0 - v : v;
    endfunction

    // Mostly physical particles, some raw noise
    function automatic particle_t rand_particle();
        particle_t p;
        if ($urandom_range(0, 9) < 8)
        begin
            p.pos_x = rand_signed($urandom_range(1, 62));
            p.pos_y = rand_signed($urandom_range(1, 62));
            p.time_offset = rand_signed($urandom_range(1, 63));
            p.slope_x = rand_signed($urandom_range(1, 47));
            p.slope_y = rand_signed($urandom_range(1, 47));
            p.momentum_dev = rand_signed($urandom_range(1, 48));
        end
        else
        begin
            p.pos_x = rand64();
            p.pos_y = rand64();
            p.time_offset = rand64();
            p.slope_x = rand64();
            p.slope_y = rand64();
            p.momentum_dev = rand64();
        end
        return p;
    endfunction

    // Sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_ch.valid <= 1'b0;
        end
        else if (!particle_ch.valid || particle_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                particle_ch.valid <= 1'b0;
            end
            else if (pending_particles.size() > 0)
            begin
                particle_t p;
                p = pending_particles.pop_front();
                particle_ch.valid <= 1'b1;
                particle_ch.pos_x <= p.pos_x;
                particle_ch.slope_x <= p.slope_x;
                particle_ch.pos_y <= p.pos_y;
                particle_ch.slope_y <= p.slope_y;
                particle_ch.time_offset <= p.time_offset;
                particle_ch.momentum_dev <= p.momentum_dev;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                particle_ch.valid <= 1'b0;
        end
    end

    // Receiver: alternate open stretches and stall patterns
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(10, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= (mode_left % 16) < 3;
            endcase
        end
    end

    // Predict on each accepted particle transaction
    always @(posedge clk)
    begin
        if (rst_n && particle_ch.valid && particle_ch.ready)
            expected_drifts.push_back(predict_drift({particle_ch.pos_x, particle_ch.slope_x,
                particle_ch.pos_y, particle_ch.slope_y, particle_ch.time_offset,
                particle_ch.momentum_dev}));
    end

    // Check each accepted result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            drift_t got;
            drift_t want;
            got = {result_ch.new_x, result_ch.new_y, result_ch.new_time_offset,
                   result_ch.math_error};
            if (expected_drifts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result x=%h y=%h cdt=%h err=%b",
                             got.new_x, got.new_y, got.new_time_offset, got.math_error);
            end
            else
            begin
                want = expected_drifts.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp x=%h y=%h cdt=%h err=%b got x=%h y=%h cdt=%h err=%b",
                                 want.new_x, want.new_y, want.new_time_offset, want.math_error,
                                 got.new_x, got.new_y, got.new_time_offset, got.math_error);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_DRIFT_LENGTH: len_reg = val;
            CFG_REF_MOMENTUM: mom_reg = val[62:0];
            CFG_MASS:         mass_reg = val[62:0];
            CFG_REF_CDT:      tref_reg = val;
            default: ;
        endcase
    endtask

    // Wait until no transaction is queued, offered or awaiting its result
    task automatic drain();
        while (pending_particles.size() > 0 || particle_ch.valid || expected_drifts.size() > 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
    endtask

    task automatic add_particle(input logic [63:0] px, sx, py, sy, t, dpop);
        pending_particles.push_back({px, sx, py, sy, t, dpop});
    endtask

    task automatic add_random(input int count);
        repeat (count) pending_particles.push_back(rand_particle());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners at reset settings
        add_particle(0, 0, 0, 0, 0, 0);
        add_particle(ONE, ONE >> 3, -ONE, -(ONE >> 4), ONE, 64'd0 - ONE);
        add_particle(5, ONE, 7, 0, 9, 0);
        add_particle(5, ONE >> 1, 7, -(ONE >> 1), 9, 0);
        add_particle(S64MAX, ONE >> 2, S64MIN, -(ONE >> 2), S64MAX, 0);
        add_particle(S64MIN, -(ONE >> 2), S64MAX, ONE >> 2, S64MIN, 0);
        add_particle(1, 0, 2, 0, 3, S64MAX);
        add_particle(1, S64MIN, 2, S64MAX, 3, S64MAX);
        add_particle(1, 3, 2, 4, 3, S64MIN);
        add_particle(-1, ONE >> 6, -2, ONE >> 7, S64MIN, -(ONE * 3));
        add_particle(S64MAX, S64MAX, S64MIN, S64MIN, S64MAX, S64MIN);
        add_particle('1, '1, '1, '1, '1, '1);
        add_particle(12345, 1, 678, -1, -99, 64'd0 - ONE + 1);
        add_particle(0, ONE - 1, 0, 0, 0, 0);
        add_particle(0, 0, 0, 0, S64MAX, ONE << 10);
        add_random(420);
        drain();

        // Extreme settings: most negative length, tiny momentum, huge mass
        write_reg(CFG_DRIFT_LENGTH, S64MIN);
        write_reg(CFG_REF_MOMENTUM, 64'd1);
        write_reg(CFG_MASS, '1);
        write_reg(CFG_REF_CDT, S64MAX);
        add_particle(0, ONE >> 3, 0, -(ONE >> 3), 0, S64MAX);
        add_particle(0, 0, 0, 0, S64MIN, ONE);
        add_random(260);
        drain();

        // Largest length and momentum, zero mass
        write_reg(CFG_DRIFT_LENGTH, S64MAX);
        write_reg(CFG_REF_MOMENTUM, '1);
        write_reg(CFG_MASS, 0);
        write_reg(CFG_REF_CDT, S64MIN);
        add_random(260);
        drain();

        // Zero momentum register: every particle flags an error
        write_reg(CFG_DRIFT_LENGTH, 0);
        write_reg(CFG_REF_MOMENTUM, 0);
        write_reg(CFG_UNUSED, '1);
        add_random(40);
        drain();

        // Moderate random settings
        write_reg(CFG_DRIFT_LENGTH, rand_signed(52));
        write_reg(CFG_REF_MOMENTUM, rand64() >> $urandom_range(8, 24));
        write_reg(CFG_MASS, rand64() >> $urandom_range(8, 24));
        write_reg(CFG_REF_CDT, rand_signed(56));
        add_random(300);
        drain();

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
